// ----- rtl/core/sdtq_pkg.sv -----
package sdtq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int TAG_W  = 8;
   localparam int TIME_W = 64;

   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_CANCEL  = 2'd1;
   localparam logic [1:0] OP_ADVANCE = 2'd2;

   localparam logic [1:0] KIND_EXPIRED   = 2'd0;
   localparam logic [1:0] KIND_CANCELLED = 2'd1;
   localparam logic [1:0] KIND_REJECTED  = 2'd2;
   localparam logic [1:0] KIND_SUMMARY   = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REPLY,
      ST_EXPIRE
   } state_type;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_CANCEL,
      CMD_SHIFT
   } cell_cmd_type;

   typedef struct packed {
      logic [1:0]        operation;
      logic [TAG_W-1:0]  timer_tag;
      logic [TIME_W-1:0] deadline;
      logic [TIME_W-1:0] now_time;
   } req_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [TAG_W-1:0]  done_tag;
      logic [TIME_W-1:0] next_delay;
      logic              timer_pending;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [TAG_W-1:0]  tag;
      logic [TIME_W-1:0] deadline;
   } cell_data_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      cell_cmd_type      cmd;
      logic [TAG_W-1:0]  tag;
      logic [TIME_W-1:0] key;
   } cell_ctl_type;

   // flags handed from one cell to the next one down the chain
   typedef struct packed {
      logic keep;
      logic found;
   } cell_flags_type;

endpackage

// ----- rtl/core/sdtq_cell.sv -----
module sdtq_cell
   import sdtq_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cell_ctl_type   ctl,
   input  cell_data_type  prev_data,
   input  cell_flags_type prev_flags,
   input  cell_data_type  next_data,
   output cell_data_type  data,
   output cell_flags_type flags
);

   cell_data_type data_ff, data_in;
   logic          match;

   assign match       = data_ff.valid && (data_ff.tag == ctl.tag);
   // keep: this entry stays ahead of the new deadline (ties stay ahead)
   assign flags.keep  = data_ff.valid && (data_ff.deadline <= ctl.key);
   assign flags.found = prev_flags.found || match;
   assign data        = data_ff;

   always_comb begin
      data_in = data_ff;
      case (ctl.cmd)
         CMD_INSERT: begin
            if (!flags.keep) begin
               if (prev_flags.keep) begin
                  data_in.valid    = 1'b1;
                  data_in.tag      = ctl.tag;
                  data_in.deadline = ctl.key;
               end else begin
                  data_in = prev_data;
               end
            end
         end
         CMD_CANCEL: begin
            if (flags.found) begin
               data_in = next_data;
            end
         end
         CMD_SHIFT: begin
            data_in = next_data;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else begin
         data_ff.valid <= data_in.valid;
      end
      data_ff.tag      <= data_in.tag;
      data_ff.deadline <= data_in.deadline;
   end

endmodule

// ----- rtl/core/sorted_deadline_timer_queue.sv -----
// Sorted timer queue: up to DEPTH timers (8-bit tag, 64-bit absolute deadline)
// held in a row of cells, head in cell 0, ordered by deadline, ties in arrival order.
// Input channel: req_data is taken at a clock edge where start is high and busy is low.
// Result channel: each result sits on rsp_data for one cycle with rsp_valid high;
// the receiver cannot stall, so results are never held back.
// Insert: every cell compares against the new deadline in the accept cycle and the
// row opens a slot at the accept edge; a successful insert gives no result and the next
// item may follow in the next cycle. A full queue rejects: the reply state issues one
// result and holds busy meanwhile.
// Cancel: the first matching entry is dropped and the row closes up at the accept
// edge; the reply state then issues one result and holds busy, so requests wait.
// Advance: one expired timer leaves the head per cycle (the row shifts by one), then
// a summary with the delay to the new head. An advance that expires N timers stays
// busy in the expire state until the summary and delivers N + 1 results.
// Reset clears the valid bit of every cell and returns the control to idle; the
// queue is then empty. No clearing pass is needed.
module sorted_deadline_timer_queue
   import sdtq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   state_type         state_ff, state_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic [1:0]        kind_ff, kind_in;
   logic              pending_ff, pending_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   cell_ctl_type      ctl;
   cell_data_type     cell_q [DEPTH];
   cell_flags_type    flag_q [DEPTH];
   logic [DEPTH-1:0]  valid_vec;
   logic [DEPTH-1:0]  late_vec;
   logic [DEPTH-1:0]  valid_inc;

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         cell_data_type  prev_data;
         cell_flags_type prev_flags;
         cell_data_type  next_data;

         if (i == 0) begin : g_head
            assign prev_data        = '0;
            assign prev_flags.keep  = 1'b1;
            assign prev_flags.found = 1'b0;
         end else begin : g_body
            assign prev_data  = cell_q[i-1];
            assign prev_flags = flag_q[i-1];
         end

         if (i == DEPTH - 1) begin : g_tail
            assign next_data = '0;
         end else begin : g_link
            assign next_data = cell_q[i+1];
         end

         sdtq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .prev_data  (prev_data),
            .prev_flags (prev_flags),
            .next_data  (next_data),
            .data       (cell_q[i]),
            .flags      (flag_q[i])
         );

         assign valid_vec[i] = cell_q[i].valid;
         assign late_vec[i]  = cell_q[i].valid && !flag_q[i].keep;
      end
   endgenerate

   assign valid_inc = valid_vec + DEPTH'(1);

   always_comb begin
      state_in     = state_ff;
      now_in       = now_ff;
      tag_in       = tag_ff;
      kind_in      = kind_ff;
      pending_in   = pending_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      ctl.cmd      = CMD_HOLD;
      ctl.tag      = req_data.timer_tag;
      ctl.key      = now_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_data.operation)
                  OP_INSERT: begin
                     ctl.key = req_data.deadline;
                     if (valid_vec[DEPTH-1]) begin
                        kind_in  = KIND_REJECTED;
                        tag_in   = req_data.timer_tag;
                        state_in = ST_REPLY;
                     end else begin
                        ctl.cmd = CMD_INSERT;
                     end
                  end
                  OP_CANCEL: begin
                     ctl.cmd  = CMD_CANCEL;
                     kind_in  = KIND_CANCELLED;
                     tag_in   = req_data.timer_tag;
                     state_in = ST_REPLY;
                  end
                  OP_ADVANCE: begin
                     // survivors are those already later than now
                     ctl.key    = req_data.now_time;
                     now_in     = req_data.now_time;
                     pending_in = |late_vec;
                     state_in   = ST_EXPIRE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_REPLY: begin
            rsp_valid_in         = 1'b1;
            rsp_in.kind          = kind_ff;
            rsp_in.done_tag      = tag_ff;
            rsp_in.timer_pending = cell_q[0].valid;
            rsp_in.last          = 1'b1;
            state_in             = ST_IDLE;
         end
         ST_EXPIRE: begin
            rsp_valid_in = 1'b1;
            if (flag_q[0].keep) begin
               ctl.cmd              = CMD_SHIFT;
               rsp_in.kind          = KIND_EXPIRED;
               rsp_in.done_tag      = cell_q[0].tag;
               rsp_in.timer_pending = pending_ff;
            end else begin
               rsp_in.kind          = KIND_SUMMARY;
               rsp_in.timer_pending = cell_q[0].valid;
               rsp_in.last          = 1'b1;
               if (cell_q[0].valid) begin
                  rsp_in.next_delay = cell_q[0].deadline - now_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff     <= now_in;
      tag_ff     <= tag_in;
      kind_ff    <= kind_in;
      pending_ff <= pending_in;
      rsp_ff     <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // occupied cells always form a solid run from the head
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (valid_vec & valid_inc) == '0)
      else $error("queue cells are not contiguous from the head");

   a_expired_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == KIND_EXPIRED) |-> !rsp_data.last)
      else $error("expired item marked last");

   a_advance_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.operation == OP_ADVANCE) |=> busy)
      else $error("advance accepted without going busy");

   a_empty_summary: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == KIND_SUMMARY && !rsp_data.timer_pending)
      |-> (rsp_data.next_delay == '0))
      else $error("summary on empty queue has nonzero delay");

endmodule
